/* rtl/core/mpfa_pkg.sv */
// Shared types and constants for the multi-period frame averager.
`timescale 1ns / 1ps
`default_nettype none
package mpfa_pkg;
    localparam int FRAC_BITS = 8;
    localparam int REP_W = 24;

    typedef enum logic [2:0] {
        REG_SLOTS  = 3'd0,
        REG_PER0   = 3'd1,
        REG_PER1   = 3'd2,
        REG_PER2   = 3'd3,
        REG_PER3   = 3'd4,
        REG_PIXELS = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_PEAK = 2'd1,
        ST_MEAN = 2'd2,
        ST_EMIT = 2'd3
    } t_div_state;
endpackage
`default_nettype wire

/* rtl/core/mpfa_div.sv */
// Restoring divider: one quotient bit per cycle, quotient clipped to the report range.
`timescale 1ns / 1ps
`default_nettype none
module mpfa_div
    import mpfa_pkg::*;
#(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [NUM_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]   i_den,
    output logic                    o_done,
    output logic [REP_W-1:0]        o_quo
);
    localparam int CW = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] r_num, n_num;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [DEN_W:0]   w_sh;

    always_comb begin
        w_sh   = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_num  = i_num;
            n_quo  = '0;
            n_rem  = '0;
            n_cnt  = CW'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[NUM_W-2:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quo  = (|r_quo[NUM_W-1:REP_W]) ? {REP_W{1'b1}} : r_quo[REP_W-1:0];
endmodule
`default_nettype wire

/* rtl/core/mpfa_back.sv */
// Report back end: divides peak and total per completing slot and presents reports.
`timescale 1ns / 1ps
`default_nettype none
module mpfa_back
    import mpfa_pkg::*;
#(
    parameter int NUM_SLOTS = 4,
    parameter int SUM_W = 26,
    parameter int TOT_W = 56,
    parameter int PER_W = 11,
    parameter int NPX_W = 15
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_req_valid,
    output logic                          o_req_stall,
    input  wire logic [NUM_SLOTS-1:0]     i_req_mask,
    input  wire logic [NUM_SLOTS*SUM_W-1:0] i_req_peak,
    input  wire logic [NUM_SLOTS*TOT_W-1:0] i_req_total,
    input  wire logic [NUM_SLOTS*PER_W-1:0] i_req_period,
    input  wire logic [NPX_W-1:0]         i_req_npix,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [1:0]                    o_slot_index,
    output logic [REP_W-1:0]              o_peak_average,
    output logic [REP_W-1:0]              o_mean_level,
    output logic                          o_last_of_run
);
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int NUM_W = TOT_W + FRAC_BITS;
    localparam int DEN_W = PER_W + NPX_W;

    t_div_state r_st, n_st;
    logic [NUM_SLOTS-1:0] r_mask, n_mask;
    logic [NUM_SLOTS*SUM_W-1:0] r_peak;
    logic [NUM_SLOTS*TOT_W-1:0] r_tot;
    logic [NUM_SLOTS*PER_W-1:0] r_per;
    logic [NPX_W-1:0] r_npix;
    logic [SW-1:0] w_slot;
    logic [REP_W-1:0] r_pk_q;
    logic w_start;
    logic [NUM_W-1:0] w_num;
    logic [DEN_W-1:0] w_den;
    logic w_done;
    logic [REP_W-1:0] w_quo;
    logic [NUM_SLOTS-1:0] w_rest;
    logic [PER_W-1:0] w_per;
    logic [DEN_W-1:0] r_npp;

    always_comb begin
        w_slot = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
            if (r_mask[s]) w_slot = SW'(s);
        w_rest = r_mask;
        w_rest[w_slot] = 1'b0;
        w_per = r_per[w_slot*PER_W +: PER_W];
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_req_valid && |i_req_mask) n_st = ST_PEAK;
            ST_PEAK: if (w_done) n_st = ST_MEAN;
            ST_MEAN: if (w_done) n_st = ST_EMIT;
            ST_EMIT: if (!i_stall) n_st = (|w_rest) ? ST_PEAK : ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_req_stall = (r_st != ST_IDLE);
        w_start = 1'b0;
        w_num = {{(NUM_W-SUM_W-FRAC_BITS){1'b0}}, r_peak[w_slot*SUM_W +: SUM_W],
                 {FRAC_BITS{1'b0}}};
        w_den = DEN_W'(w_per);
        n_mask = r_mask;
        case (r_st)
            ST_IDLE: begin
                n_mask = i_req_mask;
                w_start = i_req_valid && |i_req_mask;
                w_num = {{(NUM_W-SUM_W-FRAC_BITS){1'b0}},
                         i_req_peak[0 +: SUM_W], {FRAC_BITS{1'b0}}};
            end
            ST_PEAK: begin
                w_start = w_done;
                w_num = {r_tot[w_slot*TOT_W +: TOT_W], {FRAC_BITS{1'b0}}};
                w_den = r_npp;
            end
            ST_MEAN: ;
            ST_EMIT: begin
                if (!i_stall) begin
                    n_mask = w_rest;
                    w_start = |w_rest;
                end
            end
            default: ;
        endcase
    end

    // first divide in a run must use the first set slot of the incoming mask
    logic [SW-1:0] w_islot;
    logic [NUM_W-1:0] w_dnum;
    logic [DEN_W-1:0] w_dden;
    logic [NUM_SLOTS-1:0] w_rm;
    always_comb begin
        w_rm = w_rest;
        w_islot = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
            if (i_req_mask[s]) w_islot = SW'(s);
        w_dnum = w_num;
        w_dden = w_den;
        if (r_st == ST_IDLE) begin
            w_dnum = {{(NUM_W-SUM_W-FRAC_BITS){1'b0}},
                      i_req_peak[w_islot*SUM_W +: SUM_W], {FRAC_BITS{1'b0}}};
            w_dden = DEN_W'(i_req_period[w_islot*PER_W +: PER_W]);
        end else if (r_st == ST_EMIT) begin
            // next slot after the one just emitted
            w_dnum = {{(NUM_W-SUM_W-FRAC_BITS){1'b0}}, r_peak[0 +: SUM_W],
                      {FRAC_BITS{1'b0}}};
            w_dden = DEN_W'(r_per[0 +: PER_W]);
            for (int s = NUM_SLOTS - 1; s >= 0; s--)
                if (w_rm[s]) begin
                    w_dnum = {{(NUM_W-SUM_W-FRAC_BITS){1'b0}},
                              r_peak[s*SUM_W +: SUM_W], {FRAC_BITS{1'b0}}};
                    w_dden = DEN_W'(r_per[s*PER_W +: PER_W]);
                end
        end
    end

    mpfa_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_mask <= '0;
        end else begin
            r_st   <= n_st;
            r_mask <= n_mask;
        end
        if (r_st == ST_IDLE && i_req_valid) begin
            r_peak <= i_req_peak;
            r_tot  <= i_req_total;
            r_per  <= i_req_period;
            r_npix <= i_req_npix;
        end
        if (r_st == ST_PEAK && w_done) r_pk_q <= w_quo;
        r_npp <= DEN_W'(w_per) * DEN_W'(r_npix);
        if (r_st == ST_MEAN && w_done) o_mean_level <= w_quo;
    end

    assign o_valid        = (r_st == ST_EMIT);
    assign o_slot_index   = 2'(w_slot);
    assign o_peak_average = r_pk_q;
    assign o_last_of_run  = ~|w_rest;
endmodule
`default_nettype wire

/* rtl/core/mpfa_front.sv */
// Pixel front end: accumulates per-slot sums in memory, tracks peaks and totals, counts frames.
`timescale 1ns / 1ps
`default_nettype none
module mpfa_front
    import mpfa_pkg::*;
#(
    parameter int NUM_SLOTS = 4,
    parameter int MAX_PIXELS = 16384,
    parameter int PIXEL_BITS = 16,
    parameter int MAX_PERIOD = 1024,
    parameter int SUM_W = 26,
    parameter int TOT_W = 56,
    parameter int PER_W = 11,
    parameter int NPX_W = 15
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [2:0]                 i_cfg_idx,
    input  wire logic [NPX_W-1:0]           i_cfg_data,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [PIXEL_BITS-1:0]      i_pixel_value,
    output logic                            o_req_valid,
    input  wire logic                       i_req_stall,
    output logic [NUM_SLOTS-1:0]            o_req_mask,
    output logic [NUM_SLOTS*SUM_W-1:0]      o_req_peak,
    output logic [NUM_SLOTS*TOT_W-1:0]      o_req_total,
    output logic [NUM_SLOTS*PER_W-1:0]      o_req_period,
    output logic [NPX_W-1:0]                o_req_npix
);
    localparam int PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int AW = SW + PW;
    localparam int DEPTH = NUM_SLOTS * (2 ** PW);
    localparam int FLW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam logic [SUM_W-1:0] SUM_CAP =
        SUM_W'(((64'd1 << PIXEL_BITS) - 64'd1) * 64'(MAX_PERIOD));
    localparam int CW = $clog2(NUM_SLOTS + 1);

    logic [SUM_W-1:0] r_mem [DEPTH];
    logic [3:0] r_cfg_slots;
    logic [PER_W-1:0] r_per [NUM_SLOTS];
    logic [NPX_W-1:0] r_cfg_npix;
    logic [FLW-1:0] r_left [NUM_SLOTS];
    logic [PW:0] r_pos;
    logic [SUM_W-1:0] r_peak [NUM_SLOTS];
    logic [TOT_W-1:0] r_tot [NUM_SLOTS];
    logic r_clr;
    logic [AW:0] r_clr_addr;

    // sweep of slots for one pixel
    logic r_busy;
    logic [SW-1:0] r_slot;
    logic [PIXEL_BITS-1:0] r_pix;
    logic [PW-1:0] r_ppos;
    logic r_fend;
    logic r_rd_ok;
    logic [SUM_W-1:0] r_rd;
    logic [SW-1:0] r_rslot;
    logic r_rlast;

    logic [CW-1:0] w_nslots;
    logic [NPX_W-1:0] w_npix;
    logic [PW:0] w_pos;
    logic w_fend;
    logic w_acc;
    logic [SUM_W:0] w_sum_raw;
    logic [SUM_W-1:0] w_sum;
    logic [TOT_W:0] w_tot_raw;
    logic r_emit_pend;
    logic [NUM_SLOTS-1:0] w_mask;

    function automatic logic [PER_W-1:0] clamp_per(input logic [PER_W-1:0] v);
        if (v == '0) return PER_W'(1);
        if (32'(v) > 32'(MAX_PERIOD)) return PER_W'(MAX_PERIOD);
        return v;
    endfunction

    always_comb begin
        w_nslots = (r_cfg_slots == '0) ? CW'(1) :
                   (r_cfg_slots > 4'(NUM_SLOTS)) ? CW'(NUM_SLOTS) : CW'(r_cfg_slots);
        w_npix = (r_cfg_npix == '0) ? NPX_W'(1) :
                 (32'(r_cfg_npix) > 32'(MAX_PIXELS)) ? NPX_W'(MAX_PIXELS) : r_cfg_npix;
        w_pos = (r_pos >= (PW+1)'(w_npix)) ? (PW+1)'(w_npix - 1'b1) : r_pos;
        w_fend = ((PW+2)'(w_pos) + 1'b1 >= (PW+2)'(w_npix));
        w_acc = i_valid && !o_stall;
        w_sum_raw = {1'b0, r_rd} + (SUM_W+1)'(r_pix);
        w_sum = (w_sum_raw > (SUM_W+1)'(SUM_CAP)) ? SUM_CAP : w_sum_raw[SUM_W-1:0];
        w_tot_raw = {1'b0, r_tot[r_rslot]} + (TOT_W+1)'(w_sum);
        for (int s = 0; s < NUM_SLOTS; s++)
            w_mask[s] = (CW'(s) < w_nslots) && (r_left[s] == '0);
    end

    assign o_stall = r_busy || r_rd_ok || r_clr || r_emit_pend;

    always_ff @(posedge i_clk) begin
        if (r_clr) r_mem[r_clr_addr[AW-1:0]] <= '0;
        else if (r_rd_ok)
            r_mem[{r_rslot, r_ppos}] <= (r_left[r_rslot] == '0) ? '0 : w_sum;
        if (r_busy) r_rd <= r_mem[{r_slot, r_ppos}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_slots <= 4'd1;
            r_cfg_npix  <= NPX_W'(MAX_PIXELS);
            r_pos <= '0;
            r_clr <= 1'b1;
            r_clr_addr <= '0;
            r_busy <= 1'b0;
            r_rd_ok <= 1'b0;
            r_emit_pend <= 1'b0;
            o_req_valid <= 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_per[s] <= PER_W'(1);
                r_left[s] <= '0;
                r_peak[s] <= '0;
                r_tot[s] <= '0;
            end
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == (AW+1)'(DEPTH - 1)) r_clr <= 1'b0;
            end
            // hand off the frame end once slot state is settled
            if (r_emit_pend && !(o_req_valid && i_req_stall)) begin
                r_emit_pend <= 1'b0;
                o_req_valid <= |w_mask;
                o_req_mask <= w_mask;
                o_req_npix <= w_npix;
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    o_req_peak[s*SUM_W +: SUM_W] <= r_peak[s];
                    o_req_total[s*TOT_W +: TOT_W] <= r_tot[s];
                    o_req_period[s*PER_W +: PER_W] <= clamp_per(r_per[s]);
                    if (CW'(s) < w_nslots) begin
                        if (r_left[s] == '0) begin
                            r_left[s] <= FLW'(clamp_per(r_per[s]) - 1'b1);
                            r_peak[s] <= '0;
                            r_tot[s] <= '0;
                        end else r_left[s] <= r_left[s] - 1'b1;
                    end
                end
            end else if (o_req_valid && !i_req_stall) o_req_valid <= 1'b0;
            r_rd_ok <= r_busy;
            r_rslot <= r_slot;
            r_rlast <= r_busy && (SW+1)'(r_slot) + 1'b1 == (SW+1)'(w_nslots);
            if (r_rd_ok) begin
                if (r_left[r_rslot] == '0) begin
                    if (w_sum > r_peak[r_rslot]) r_peak[r_rslot] <= w_sum;
                    r_tot[r_rslot] <= w_tot_raw[TOT_W] ? {TOT_W{1'b1}} : w_tot_raw[TOT_W-1:0];
                end
                if (r_rlast && r_fend) r_emit_pend <= 1'b1;
            end
            if (r_busy) begin
                if ((SW+1)'(r_slot) + 1'b1 == (SW+1)'(w_nslots)) r_busy <= 1'b0;
                else r_slot <= r_slot + 1'b1;
            end
            if (w_acc) begin
                r_busy <= 1'b1;
                r_slot <= '0;
                r_pix <= i_pixel_value;
                r_ppos <= w_pos[PW-1:0];
                r_fend <= w_fend;
                r_pos <= w_fend ? '0 : w_pos + 1'b1;
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_SLOTS, REG_PIXELS: begin
                        if (i_cfg_idx == REG_SLOTS) r_cfg_slots <= {1'b0, i_cfg_data[2:0]};
                        else r_cfg_npix <= i_cfg_data;
                        r_pos <= '0;
                        for (int s = 0; s < NUM_SLOTS; s++) begin
                            r_peak[s] <= '0;
                            r_tot[s] <= '0;
                        end
                    end
                    REG_PER0, REG_PER1, REG_PER2, REG_PER3: begin
                        for (int s = 0; s < NUM_SLOTS; s++)
                            if (3'(s + 1) == i_cfg_idx) begin
                                r_per[s] <= i_cfg_data[PER_W-1:0];
                                r_left[s] <= FLW'(clamp_per(i_cfg_data[PER_W-1:0]) - 1'b1);
                            end
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/multi_period_frame_averager_core.sv */
// Top level of the multi-period frame averager.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one pixel per request and adds it into the sum memory of each active slot, one
// slot per cycle through one read and one write port; the pixel input stalls until the
// sweep is through. At frame end the slots on their final frame are handed to a report
// unit that runs a bit-serial divide twice per report, peak then mean, and takes no new
// frame end until its last report has left the output. A frame end that finds an earlier
// one still waiting for the report unit holds the pixel input until it is taken. After
// reset a clearing pass zeroes the whole sum memory before pixels are taken.
module multi_period_frame_averager_core
    import mpfa_pkg::*;
#(
    parameter int NUM_SLOTS = 4,
    parameter int MAX_PIXELS = 16384,
    parameter int PIXEL_BITS = 16,
    parameter int MAX_PERIOD = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [2:0]            i_cfg_idx,
    input  wire logic [14:0]           i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [PIXEL_BITS-1:0] i_pixel_value,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [1:0]                 o_slot_index,
    output logic [REP_W-1:0]           o_peak_average,
    output logic [REP_W-1:0]           o_mean_level,
    output logic                       o_last_of_run
);
    localparam int SUM_W = PIXEL_BITS + $clog2(MAX_PERIOD + 1);
    localparam int TOT_W = 56;
    localparam int PER_W = 11;
    localparam int NPX_W = 15;

    logic rq_valid, rq_stall;
    logic [NUM_SLOTS-1:0] rq_mask;
    logic [NUM_SLOTS*SUM_W-1:0] rq_peak;
    logic [NUM_SLOTS*TOT_W-1:0] rq_total;
    logic [NUM_SLOTS*PER_W-1:0] rq_period;
    logic [NPX_W-1:0] rq_npix;

    mpfa_front #(
        .NUM_SLOTS(NUM_SLOTS), .MAX_PIXELS(MAX_PIXELS), .PIXEL_BITS(PIXEL_BITS),
        .MAX_PERIOD(MAX_PERIOD), .SUM_W(SUM_W), .TOT_W(TOT_W), .PER_W(PER_W),
        .NPX_W(NPX_W)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_pixel_value(i_pixel_value),
        .o_req_valid(rq_valid), .i_req_stall(rq_stall), .o_req_mask(rq_mask),
        .o_req_peak(rq_peak), .o_req_total(rq_total), .o_req_period(rq_period),
        .o_req_npix(rq_npix)
    );

    mpfa_back #(
        .NUM_SLOTS(NUM_SLOTS), .SUM_W(SUM_W), .TOT_W(TOT_W), .PER_W(PER_W),
        .NPX_W(NPX_W)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(rq_valid), .o_req_stall(rq_stall), .i_req_mask(rq_mask),
        .i_req_peak(rq_peak), .i_req_total(rq_total), .i_req_period(rq_period),
        .i_req_npix(rq_npix),
        .o_valid(o_valid), .i_stall(i_stall), .o_slot_index(o_slot_index),
        .o_peak_average(o_peak_average), .o_mean_level(o_mean_level),
        .o_last_of_run(o_last_of_run)
    );

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_slot_index))
        else $error("report dropped while stalled");
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rq_valid && rq_stall |=> rq_valid && $stable(rq_mask))
        else $error("frame-end request changed while stalled");
`endif
endmodule
`default_nettype wire

/* sim/tb_multi_period_frame_averager_core.sv */
// Testbench for the multi-period frame averager: random and directed pixels against a predictor.
`timescale 1ns / 1ps
module tb_multi_period_frame_averager_core;
    import mpfa_pkg::*;

    localparam int NSLOT = 4;
    localparam int MAXPIX = 16384;
    localparam int MAXPER = 1024;
    localparam longint unsigned SUM_CAP = 64'd65535 * MAXPER;
    localparam longint unsigned TOTAL_CAP = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS;
    localparam longint unsigned REPORT_CAP = 64'hFF_FFFF;
    localparam logic [2:0] REG_UNUSED_LO = 3'd6;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;
    localparam int SETTLE_CYCLES = 400;

    typedef struct packed {
        logic [1:0]       slot;
        logic [REP_W-1:0] peak;
        logic [REP_W-1:0] mean;
        logic             last;
    } t_report;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [2:0]        i_cfg_idx = '0;
    logic [14:0]       i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [15:0]       i_pixel_value = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        o_slot_index;
    logic [REP_W-1:0]  o_peak_average;
    logic [REP_W-1:0]  o_mean_level;
    logic              o_last_of_run;

    multi_period_frame_averager_core u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [2:0]      slots_reg;
    logic [10:0]     period_reg [NSLOT];
    logic [14:0]     pixels_reg;
    logic [25:0]     pixel_sum [NSLOT*MAXPIX];
    longint unsigned frames_left [NSLOT];
    longint unsigned run_peak [NSLOT];
    longint unsigned run_total [NSLOT];
    longint unsigned position;

    t_report pending_reports[$];
    int      mismatches = 0;
    int      pixels_sent = 0;
    int      reports_seen = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    function automatic longint unsigned clamp(longint unsigned v, longint unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void clear_trackers();
        for (int s = 0; s < NSLOT; s++) begin
            run_peak[s] = 0;
            run_total[s] = 0;
        end
    endfunction

    function automatic void model_write(logic [2:0] idx, logic [14:0] val);
        int s;
        case (idx)
            REG_SLOTS: begin
                slots_reg = val[2:0];
                position = 0;
                clear_trackers();
            end
            REG_PER0, REG_PER1, REG_PER2, REG_PER3: begin
                s = idx - REG_PER0;
                period_reg[s] = val[10:0];
                frames_left[s] = clamp(period_reg[s], MAXPER) - 1;
            end
            REG_PIXELS: begin
                pixels_reg = val;
                position = 0;
                clear_trackers();
            end
            default: ;
        endcase
    endfunction

    // Fold one accepted pixel into the sums and queue any window reports.
    function automatic void predict_pixel(logic [15:0] pix);
        longint unsigned nslots, npix, pos, idx, sum, per, pk, mn;
        int count;
        t_report rep;
        nslots = clamp(slots_reg, NSLOT);
        npix = clamp(pixels_reg, MAXPIX);
        pos = (position >= npix) ? npix - 1 : position;
        count = 0;
        for (int s = 0; s < nslots; s++) begin
            idx = s * MAXPIX + pos;
            sum = pixel_sum[idx] + pix;
            if (sum > SUM_CAP) sum = SUM_CAP;
            if (frames_left[s] == 0) begin
                if (sum > run_peak[s]) run_peak[s] = sum;
                if (run_total[s] > TOTAL_CAP - sum) run_total[s] = TOTAL_CAP;
                else run_total[s] += sum;
                pixel_sum[idx] = '0;
            end else begin
                pixel_sum[idx] = sum[25:0];
            end
        end
        if (pos + 1 < npix) begin
            position = pos + 1;
            return;
        end
        for (int s = 0; s < nslots; s++) begin
            per = clamp(period_reg[s], MAXPER);
            if (frames_left[s] == 0) begin
                pk = (run_peak[s] << FRAC_BITS) / per;
                mn = (run_total[s] << FRAC_BITS) / (npix * per);
                rep.slot = s[1:0];
                rep.peak = (pk > REPORT_CAP) ? REPORT_CAP[23:0] : pk[23:0];
                rep.mean = (mn > REPORT_CAP) ? REPORT_CAP[23:0] : mn[23:0];
                rep.last = 1'b0;
                pending_reports.insert(pending_reports.size(), rep);
                count++;
                frames_left[s] = per - 1;
                run_peak[s] = 0;
                run_total[s] = 0;
            end else begin
                frames_left[s] -= 1;
            end
        end
        if (count > 0) pending_reports[$].last = 1'b1;
        position = 0;
    endfunction

    task automatic flag(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                flag($sformatf("unexpected report slot %0d", o_slot_index));
            end else begin
                want = pending_reports.pop_front();
                if (o_slot_index !== want.slot)
                    flag($sformatf("slot %0d want %0d", o_slot_index, want.slot));
                if (o_peak_average !== want.peak)
                    flag($sformatf("peak %0h want %0h", o_peak_average, want.peak));
                if (o_mean_level !== want.mean)
                    flag($sformatf("mean %0h want %0h", o_mean_level, want.mean));
                if (o_last_of_run !== want.last)
                    flag($sformatf("last %0b want %0b", o_last_of_run, want.last));
            end
        end
    end

    // Hold the pixel until the request is taken; valid stays high for the next one.
    task automatic send_pixel(input logic [15:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_value <= pix;
        do @(posedge i_clk); while (o_stall);
        predict_pixel(pix);
        pixels_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [14:0] slots, input logic [14:0] p0,
                             input logic [14:0] p1, input logic [14:0] p2,
                             input logic [14:0] p3, input logic [14:0] npix);
        logic [14:0] vals [6];
        vals = '{slots, p0, p1, p2, p3, npix};
        drain();
        for (int r = 0; r < 6; r++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= r[2:0];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            model_write(r[2:0], vals[r]);
        end
        // out-of-range indexes must not disturb anything
        i_cfg_idx <= ($urandom_range(1)) ? REG_UNUSED_LO : REG_UNUSED_HI;
        i_cfg_data <= 15'h7FFF;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic test_zero_settings();
        // zeros clamp to one slot, period one, one pixel per frame
        configure(15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hAAAA);
        send_pixel(16'h5555);
    endtask

    task automatic test_all_slots();
        configure(15'd7, 15'd1, 15'd2, 15'd3, 15'd4, 15'd3);
        for (int i = 0; i < 12; i++) send_pixel((i % 2) ? 16'hFFFF : 16'h0001);
    endtask

    task automatic test_oversized();
        // period and frame size clamp to their maxima; no report is due
        configure(15'd4, 15'h7FF, 15'd1024, 15'd1, 15'd2, 15'h7FFF);
        for (int i = 0; i < 4; i++) send_pixel(16'hFFFF);
        configure(15'd2, 15'd1, 15'd2, 15'd1, 15'd1, 15'd2);
        for (int i = 0; i < 4; i++) send_pixel(pick_pixel());
    endtask

    task automatic test_random(input int n_items);
        logic [14:0] slots, npix;
        logic [14:0] per [4];
        int sent;
        sent = 0;
        while (sent < n_items) begin
            slots = ($urandom_range(9) == 0) ? 15'($urandom_range(7)) :
                                               15'($urandom_range(1, 4));
            for (int s = 0; s < 4; s++)
                case ($urandom_range(11))
                    0: per[s] = 15'd0;
                    1: per[s] = 15'($urandom_range(11'h7FF));
                    default: per[s] = 15'($urandom_range(1, 5));
                endcase
            npix = ($urandom_range(11) == 0) ? 15'd0 : 15'($urandom_range(1, 6));
            configure(slots, per[0], per[1], per[2], per[3], npix);
            for (int i = 0; i < 30; i++) begin
                send_pixel(pick_pixel());
                sent++;
            end
        end
    endtask

    initial begin
        slots_reg = 3'd1;
        pixels_reg = 15'd16384;
        position = 0;
        for (int s = 0; s < NSLOT; s++) begin
            period_reg[s] = 11'd1;
            frames_left[s] = 0;
        end
        clear_trackers();
        for (int k = 0; k < NSLOT * MAXPIX; k++) pixel_sum[k] = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 16;
        recv_stall_pct = 77;
        test_zero_settings();
        test_all_slots();
        test_oversized();
        test_random(120);
        send_idle_pct = 77;
        recv_stall_pct = 16;
        test_random(120);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(120);
        drain();

        $display("Sent %0d pixels across varied slot, period and frame settings.", pixels_sent);
        $display("Checked %0d window reports; %0d mismatches.", reports_seen, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout waiting on the block");
        $display("Regression FAIL");
        $finish;
    end
endmodule
